FILE: rtl/pctc_pkg.sv
`default_nettype none

package pctc_pkg;

    localparam int unsigned CLASSES     = 16;
    localparam int unsigned STACK_DEPTH = 64;
    localparam int unsigned MAX_BATCH   = 64;

    localparam int unsigned ADDR_W  = 48;
    localparam int unsigned CLS_W   = 4;
    localparam int unsigned LIMIT_W = 7;

    localparam int unsigned CIDX_W  = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int unsigned SLOT_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned FILL_W  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned CNT_W   = $clog2(MAX_BATCH + 1);
    localparam int unsigned MEM_DEPTH = CLASSES * STACK_DEPTH;
    localparam int unsigned MADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_POPPED   = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_SPILLED  = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [CLS_W-1:0]   class_index;
        logic [ADDR_W-1:0]  object_address;
        logic [LIMIT_W-1:0] batch_limit;
        logic               batch_end;
    } in_beat_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address_out;
        logic [1:0]        status;
        logic              last;
    } out_beat_t;

endpackage

`default_nettype wire

FILE: rtl/per_class_transfer_cache_core.sv
`default_nettype none

// Per-class transfer cache: one LIFO stack of free addresses per size class,
// held in a single-port slot memory with one fill counter per class. Items are
// handled one at a time. An insert is decided and its result beat registered
// in the decide state; a remove is decided there, then pops each address via
// a read and an emit state, as the slot memory's read is registered (one read
// per address). Results leave through an output register, so a stalled result
// beat only holds the sequencer at the point it wants to issue the next beat.
// Fill counters clear at reset; the slot memory needs no clearing pass.
module per_class_transfer_cache_core
    import pctc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_beat_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_READ, S_EMIT} state_t;

    state_t                state_reg, state_next;
    in_beat_t              item_reg, item_next;
    logic [FILL_W-1:0]     fill_reg [CLASSES];
    logic [FILL_W-1:0]     fill_next [CLASSES];
    logic [FILL_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  m_valid_reg, m_valid_next;
    out_beat_t             m_data_reg, m_data_next;

    logic [ADDR_W-1:0]     mem [MEM_DEPTH];
    logic [ADDR_W-1:0]     rd_data_reg;

    logic                  mem_we, mem_re;
    logic [SLOT_W-1:0]     slot;
    logic [MADDR_W-1:0]    mem_addr;
    logic                  cls_ok, out_free;
    logic [CIDX_W-1:0]     cls_idx;
    logic [FILL_W-1:0]     cur_fill;
    logic [FILL_W-1:0]     ptr_dec;
    logic [31:0]           lim_sat, take32;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign cls_ok   = (32'(item_reg.class_index) < CLASSES);
    assign cls_idx  = CIDX_W'(item_reg.class_index);
    assign cur_fill = fill_reg[cls_idx];
    assign ptr_dec  = ptr_reg - FILL_W'(1);
    assign out_free = !m_valid_reg || m_ready;

    assign lim_sat = (32'(item_reg.batch_limit) > MAX_BATCH) ? MAX_BATCH
                                                               : 32'(item_reg.batch_limit);
    assign take32  = (!cls_ok) ? 32'd0
                   : (lim_sat > 32'(cur_fill)) ? 32'(cur_fill) : lim_sat;

    assign slot     = mem_we ? SLOT_W'(cur_fill) : SLOT_W'(ptr_dec);
    assign mem_addr = MADDR_W'(MADDR_W'(cls_idx) * MADDR_W'(STACK_DEPTH))
                    + MADDR_W'(slot);

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        fill_next    = fill_reg;
        ptr_next     = ptr_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    if (item_reg.opcode == OP_INSERT) begin
                        m_valid_next = 1'b1;
                        m_data_next.address_out = '0;
                        m_data_next.last        = item_reg.batch_end;
                        if (cls_ok && (32'(cur_fill) < STACK_DEPTH)) begin
                            mem_we              = 1'b1;
                            fill_next[cls_idx]  = cur_fill + FILL_W'(1);
                            m_data_next.status  = ST_INSERTED;
                        end else begin
                            m_data_next.status  = ST_SPILLED;
                        end
                        state_next = S_IDLE;
                    end else if (take32 == 32'd0) begin
                        m_valid_next = 1'b1;
                        m_data_next.address_out = '0;
                        m_data_next.status      = ST_NONE;
                        m_data_next.last        = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        count_next = CNT_W'(take32);
                        ptr_next   = cur_fill;
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                mem_re             = 1'b1;
                ptr_next           = ptr_dec;
                fill_next[cls_idx] = ptr_dec;
                state_next         = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next.address_out = rd_data_reg;
                    m_data_next.status      = ST_POPPED;
                    m_data_next.last        = (count_reg == CNT_W'(1));
                    count_next = count_reg - CNT_W'(1);
                    state_next = (count_reg == CNT_W'(1)) ? S_IDLE : S_READ;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < CLASSES; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            fill_reg    <= fill_next;
        end
        item_reg   <= item_next;
        ptr_reg    <= ptr_next;
        count_reg  <= count_next;
        m_data_reg <= m_data_next;
    end

    // slot memory: one port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= item_reg.object_address;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

endmodule

`default_nettype wire
